@@ rtl/core/tvmu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvmu_pkg
// Shared types and constants of the truth value merge unit.
// ----------------------------------------------------------------------------
package tvmu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WEIGHT_CAP    = 1000;
  localparam int CAP_BITS      = 10;

  typedef enum logic [2:0] {
    FN_DED  = 3'd0,
    FN_IND  = 3'd1,
    FN_ABD  = 3'd2,
    FN_REV  = 3'd3,
    FN_CONJ = 3'd4,
    FN_DISJ = 3'd5,
    FN_NEG  = 3'd6
  } func_t;

endpackage

@@ rtl/core/tvmu_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvmu_div_cell
// One restoring division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
module tvmu_div_cell #(
  parameter int DW = 17,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] x_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] x_o,
  output logic [DW-1:0] den_o
);

  logic [DW:0]   t;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] x_r, x_nxt;
  logic [DW-1:0] den_r;

  always_comb begin
    t       = {rem_i, x_i[QW-1]};
    diff    = t - {1'b0, den_i};
    ge      = (t >= {1'b0, den_i});
    rem_nxt = ge ? diff[DW-1:0] : t[DW-1:0];
    x_nxt   = {x_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      x_r   <= x_nxt;
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign x_o   = x_r;
  assign den_o = den_r;

endmodule

@@ rtl/core/tvmu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvmu_div
// Pipelined divider: a chain of QW cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
module tvmu_div #(
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem_c [QW+1];
  logic [QW-1:0] x_c   [QW+1];
  logic [DW-1:0] den_c [QW];

  assign rem_c[0] = DW'(num >> QW);
  assign x_c[0]   = num[QW-1:0];
  assign den_c[0] = den;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    if (i < QW - 1) begin : g_mid
      tvmu_div_cell #(.DW(DW), .QW(QW)) u_cell (
        .clk(clk), .en(en), .rem_i(rem_c[i]), .x_i(x_c[i]), .den_i(den_c[i]),
        .rem_o(rem_c[i+1]), .x_o(x_c[i+1]), .den_o(den_c[i+1])
      );
    end else begin : g_last
      tvmu_div_cell #(.DW(DW), .QW(QW)) u_cell (
        .clk(clk), .en(en), .rem_i(rem_c[i]), .x_i(x_c[i]), .den_i(den_c[i]),
        .rem_o(rem_c[i+1]), .x_o(x_c[i+1]), .den_o()
      );
    end
  end

  assign quot = x_c[QW];
  assign rem  = rem_c[QW];

endmodule

@@ rtl/core/tvmu_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvmu_delay
// Shift line that keeps side data in step with the divider chains.
// ----------------------------------------------------------------------------
module tvmu_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

@@ rtl/core/truth_value_merge_unit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truth_value_merge_unit_top
// Merges two fixed-point truth values under a selected inference rule.
// ----------------------------------------------------------------------------
// Input channel in_*: rule selector and two (strength, confidence) pairs.
// Result channel out_*: merged strength, confidence and the accepted flag.
// Config channel cfg_*: writes the confidence threshold, always ready.
// From input transfer to result valid, the path runs through the weight
// divider chain of 2*FRAC_BITS cells and the strength/confidence divider
// chains of FRAC_BITS+1 cells. Throughput is one item per cycle while
// in_ready is high: every divider cell takes a new operand set whenever
// the pipeline is not held.
// The output register is backed by a one-entry skid buffer: while a result
// waits the pipeline keeps moving until the next result reaches the buffer,
// then the whole pipeline holds and in_ready drops; in_ready rises again
// in the cycle after the waiting result is taken.
// Reset clears all valid bits and sets the threshold to one half.
// ----------------------------------------------------------------------------
module truth_value_merge_unit_top #(
  parameter int FRAC_BITS = tvmu_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  input  logic [FRAC_BITS:0]   in_first_strength,
  input  logic [FRAC_BITS:0]   in_first_confidence,
  input  logic [FRAC_BITS:0]   in_second_strength,
  input  logic [FRAC_BITS:0]   in_second_confidence,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   out_result_strength,
  output logic [FRAC_BITS:0]   out_result_confidence,
  output logic                 out_accepted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [FRAC_BITS:0]   cfg_data
);
  import tvmu_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VW  = F + 1;
  localparam int WW  = (2 * F > F + CAP_BITS) ? 2 * F : F + CAP_BITS;
  localparam int SW  = WW + 1;
  localparam int NRS = WW + F + 2;
  localparam int DRC = WW + 2;
  localparam int NRC = 2 * F + 1;
  localparam logic [VW-1:0] ONE = VW'(1) << F;

  function automatic logic [VW-1:0] sat_one(input logic [VW-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  logic en;
  logic sv_r;

  assign en        = !sv_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // threshold
  logic [VW-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ONE >> 1;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // stage a: saturated operands
  logic          va_r;
  func_t         fn_a_r;
  logic [VW-1:0] s1_a_r, c1_a_r, s2_a_r, c2_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn_a_r <= func_t'(in_func);
      s1_a_r <= sat_one(in_first_strength);
      c1_a_r <= sat_one(in_first_confidence);
      s2_a_r <= sat_one(in_second_strength);
      c2_a_r <= sat_one(in_second_confidence);
    end
  end

  // weight dividers
  logic [2*F-1:0] q_w1, q_w2;

  tvmu_div #(.NW(2*F), .DW(VW), .QW(2*F)) u_div_w1 (
    .clk(clk), .en(en), .num({c1_a_r[F-1:0], {F{1'b0}}}), .den(ONE - c1_a_r),
    .quot(q_w1), .rem()
  );

  tvmu_div #(.NW(2*F), .DW(VW), .QW(2*F)) u_div_w2 (
    .clk(clk), .en(en), .num({c2_a_r[F-1:0], {F{1'b0}}}), .den(ONE - c2_a_r),
    .quot(q_w2), .rem()
  );

  logic [2*VW+1:0] side_w;
  tvmu_delay #(.W(2*VW+2), .N(2*F)) u_dly_w (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({s1_a_r, s2_a_r, c1_a_r[F], c2_a_r[F]}), .q(side_w)
  );

  // stage p1: capped weights
  logic [WW-1:0] w1_r, w2_r;
  logic [VW-1:0] s1_p_r, s2_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r   <= side_w[1] ? (WW'(WEIGHT_CAP) << F) : WW'(q_w1);
      w2_r   <= side_w[0] ? (WW'(WEIGHT_CAP) << F) : WW'(q_w2);
      s1_p_r <= side_w[2*VW+1:VW+2];
      s2_p_r <= side_w[VW+1:2];
    end
  end

  // stage p2: weighted sum and divisors
  logic [VW+WW-1:0] pw1, pw2;
  logic [SW-1:0]    wsum;
  logic [NRS-1:0]   nrs_r;
  logic [SW-1:0]    wsum_r;
  logic [DRC-1:0]   d_r;
  logic             zero_r;

  always_comb begin
    pw1  = s1_p_r * w1_r;
    pw2  = s2_p_r * w2_r;
    wsum = {1'b0, w1_r} + {1'b0, w2_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrs_r  <= NRS'(pw1) + NRS'(pw2);
      wsum_r <= wsum;
      d_r    <= {1'b0, wsum} + DRC'(ONE);
      zero_r <= (wsum == '0);
    end
  end

  logic [VW-1:0]  q_rs, q_rc;
  logic [DRC-1:0] r_rc;

  tvmu_div #(.NW(NRS), .DW(SW), .QW(VW)) u_div_rs (
    .clk(clk), .en(en), .num(nrs_r), .den(wsum_r), .quot(q_rs), .rem()
  );

  tvmu_div #(.NW(NRC), .DW(DRC), .QW(VW)) u_div_rc (
    .clk(clk), .en(en), .num(NRC'(1) << (2 * F)), .den(d_r), .quot(q_rc), .rem(r_rc)
  );

  logic zero_f;
  tvmu_delay #(.W(1), .N(VW)) u_dly_z (
    .clk(clk), .rst_n(rst_n), .en(en), .d(zero_r), .q(zero_f)
  );

  // stage b: direct rule products
  logic [VW-1:0]   hi, lo, f_sel;
  func_t           fn_b_r;
  logic [2*VW-1:0] ss_b_r, cc_b_r;
  logic [VW-1:0]   f_b_r, s1_b_r, s2_b_r, c1_b_r;

  always_comb begin
    hi = (s1_a_r > s2_a_r) ? s1_a_r : s2_a_r;
    lo = (s1_a_r > s2_a_r) ? s2_a_r : s1_a_r;
    case (fn_a_r)
      FN_DED:  f_sel = hi;
      FN_IND:  f_sel = ONE - hi;
      default: f_sel = ONE - lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn_b_r <= fn_a_r;
      ss_b_r <= s1_a_r * s2_a_r;
      cc_b_r <= c1_a_r * c2_a_r;
      f_b_r  <= f_sel;
      s1_b_r <= s1_a_r;
      s2_b_r <= s2_a_r;
      c1_b_r <= c1_a_r;
    end
  end

  // stage c: direct rule results
  logic [3*VW-1:0] ccf;
  logic [VW:0]     disj;
  logic [VW-1:0]   rs_c_nxt, rc_c_nxt;
  logic            rev_c_nxt;
  logic [VW-1:0]   rs_c_r, rc_c_r;
  logic            rev_c_r;

  always_comb begin
    ccf       = cc_b_r * f_b_r;
    disj      = {1'b0, s1_b_r} + {1'b0, s2_b_r} - (VW+1)'(ss_b_r >> F);
    rs_c_nxt  = '0;
    rc_c_nxt  = '0;
    rev_c_nxt = 1'b0;
    case (fn_b_r)
      FN_DED, FN_IND, FN_ABD: begin
        rs_c_nxt = VW'(ss_b_r >> F);
        rc_c_nxt = VW'(ccf >> (2 * F));
      end
      FN_CONJ: begin
        rs_c_nxt = VW'(ss_b_r >> F);
        rc_c_nxt = VW'(cc_b_r >> F);
      end
      FN_DISJ: begin
        rs_c_nxt = disj[VW-1:0];
        rc_c_nxt = VW'(cc_b_r >> F);
      end
      FN_NEG: begin
        rs_c_nxt = ONE - s1_b_r;
        rc_c_nxt = c1_b_r;
      end
      default: rev_c_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_c_r  <= rs_c_nxt;
      rc_c_r  <= rc_c_nxt;
      rev_c_r <= rev_c_nxt;
    end
  end

  logic [2*VW:0] side_f;
  tvmu_delay #(.W(2*VW+1), .N(3*F+1)) u_dly_c (
    .clk(clk), .rst_n(rst_n), .en(en), .d({rev_c_r, rs_c_r, rc_c_r}), .q(side_f)
  );

  logic v_f;
  tvmu_delay #(.W(1), .N(3*F+3)) u_dly_v (
    .clk(clk), .rst_n(rst_n), .en(en), .d(va_r), .q(v_f)
  );

  // final select
  logic [VW-1:0] ceil_q, rs_f, rc_f;
  logic          acc_f;

  always_comb begin
    ceil_q = q_rc + VW'(r_rc != '0);
    if (side_f[2*VW]) begin
      rs_f = zero_f ? (ONE >> 1) : q_rs;
      rc_f = zero_f ? '0 : ONE - ceil_q;
    end else begin
      rs_f = side_f[2*VW-1:VW];
      rc_f = side_f[VW-1:0];
    end
    acc_f = (rc_f >= thr_r);
  end

  // output register and skid buffer
  logic          ov_r;
  logic [VW-1:0] ors_r, orc_r, srs_r, src_r;
  logic          oacc_r, sacc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (ov_r && !out_ready) begin
      if (en && v_f) begin
        sv_r <= 1'b1;
      end
    end else if (sv_r) begin
      ov_r <= 1'b1;
      sv_r <= 1'b0;
    end else begin
      ov_r <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    if (ov_r && !out_ready) begin
      if (en && v_f) begin
        srs_r  <= rs_f;
        src_r  <= rc_f;
        sacc_r <= acc_f;
      end
    end else if (sv_r) begin
      ors_r  <= srs_r;
      orc_r  <= src_r;
      oacc_r <= sacc_r;
    end else begin
      ors_r  <= rs_f;
      orc_r  <= rc_f;
      oacc_r <= acc_f;
    end
  end

  assign out_valid             = ov_r;
  assign out_result_strength   = ors_r;
  assign out_result_confidence = orc_r;
  assign out_accepted          = oacc_r;

  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid entry held without a pending result");

  a_skid_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && !out_ready) |=> (sv_r && $stable(srs_r) && $stable(src_r)))
    else $error("skid entry changed while output stalled");

  a_reset_clear : assert property (@(posedge clk)
    !rst_n |=> (!ov_r && !sv_r && !v_f))
    else $error("valid state not cleared by reset");

endmodule
